>>> design/tfct_pkg.sv
// Shared types and constants for the timed frame cache table.
package tfct_pkg;

  localparam int START_W = 40;
  localparam int END_W   = 41;
  localparam int SIZE_W  = 27;
  localparam int TOL_W   = 16;
  localparam int SUM_W   = 28;
  localparam int EVC_W   = 4;
  localparam int CFG_W   = 27;

  // register indexes on the write port
  localparam logic REG_BYTE_LIMIT = 1'b0;
  localparam logic REG_CUE_TOL    = 1'b1;

  localparam logic [SIZE_W-1:0] BYTE_LIMIT_RST = 27'd16777216;
  localparam logic [TOL_W-1:0]  CUE_TOL_RST    = 16'd500;

  // one stored frame descriptor
  typedef struct packed {
    logic        [START_W-1:0] begin_ms;
    logic signed [END_W-1:0]   end_ms;
    logic        [SIZE_W-1:0]  size;
  } entry_t;

  // per-cell control for one cycle
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // take the new entry
    logic eval;   // latch the lookup match flag
  } cell_ctrl_t;

  // lookup request seen by every cell
  typedef struct packed {
    logic [START_W-1:0] query;
    logic [START_W-1:0] cue;
    logic [END_W-1:0]   cue_hi;  // cue + tolerance
    logic [TOL_W-1:0]   tol;
    logic               filter;  // cue start not negative
  } lookup_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_APPEND,
    ST_EVICT,
    ST_EVAL,
    ST_SELECT,
    ST_CLIP,
    ST_DONE
  } state_t;

endpackage

>>> design/tfct_cell.sv
// One slot of the ordered descriptor chain with its local lookup match logic.
module tfct_cell
  import tfct_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nbr,
  input  entry_t     fresh,
  input  lookup_t    lk,
  output entry_t     ent,
  output logic       start_eq,
  output logic       flag
);

  logic              far;
  logic              active;
  logic [END_W-1:0]  start_x;
  logic [END_W-1:0]  start_tol;

  assign start_eq  = (ent.begin_ms == fresh.begin_ms);
  assign start_x   = {1'b0, ent.begin_ms};
  assign start_tol = start_x + {{(END_W-TOL_W){1'b0}}, lk.tol};

  // distance to cue start above tolerance, in either direction
  assign far = (start_x > lk.cue_hi) || ({1'b0, lk.cue} > start_tol);

  assign active = (ent.begin_ms <= lk.query) &&
                  ($signed({1'b0, lk.query}) < ent.end_ms);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      ent <= nbr;
    end else if (ctrl.load) begin
      ent <= fresh;
    end
    if (ctrl.eval) begin
      flag <= active && (!lk.filter || !far);
    end
  end

endmodule

>>> design/timed_frame_cache_table.sv
// Top level of the timed frame cache table: control sequencer and cell chain.
//
// Holds up to MAX_ENTRIES frame descriptors, oldest in cell 0, newest at
// cell count-1. A request is taken when start is high and busy is low; busy
// stays high up to and including the single-cycle done strobe, which carries
// the result and cannot be held off. An insert runs in order: it drops a
// same-start entry, appends (shifting out the oldest in that same cycle when
// the table is full), checks the byte total after each shift, evicting the
// oldest entry for the byte limit (0 to MAX_ENTRIES evictions) while it is
// exceeded, and then posts the result. An insert of zero bytes goes straight
// to done. A lookup runs in order: every cell checks its entry at once, the
// newest match is picked through the priority chain, the end is clipped to
// the cue end, and the result is posted. One request is in flight at a time,
// so a new request is taken only after done. Configuration writes land at
// once and are meant for idle time only.
module timed_frame_cache_table
  import tfct_pkg::*;
#(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // request side
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic        [START_W-1:0] frame_start,
  input  logic signed [END_W-1:0]   end_ms,
  input  logic        [START_W-1:0] query_ms,
  input  logic signed [END_W-1:0]   cue_start,
  input  logic        [SIZE_W-1:0]  frame_size,
  // result side
  output logic                     done,
  output logic                     hit,
  output logic        [START_W-1:0] hit_start_ms,
  output logic        [START_W-1:0] hit_end_ms,
  output logic        [3:0]         entry_count,
  output logic        [SIZE_W-1:0]  total_size,
  output logic        [EVC_W-1:0]   evicted,
  // configuration
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic        [CFG_W-1:0]   wr_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t state, state_next;

  // configuration
  logic [SIZE_W-1:0] byte_limit;
  logic [TOL_W-1:0]  cue_tol;

  // table bookkeeping
  logic [CW-1:0]    count, count_next;
  logic [SUM_W-1:0] size_sum, size_sum_next;
  logic [EVC_W-1:0] ev, ev_next;

  // latched request
  logic                     req_mode;
  entry_t                   req;
  logic        [START_W-1:0] req_query;
  logic signed [END_W-1:0]   req_cue;
  logic        [END_W-1:0]   cue_hi;
  lookup_t                  lk;

  // lookup result
  logic                     hit_q;
  logic        [START_W-1:0] hs_q;
  logic signed [END_W-1:0]   he_raw;
  logic        [START_W-1:0] he_q;

  // cell chain
  entry_t     ent      [MAX_ENTRIES];
  entry_t     nbr      [MAX_ENTRIES];
  cell_ctrl_t ctrl     [MAX_ENTRIES];
  logic       start_eq [MAX_ENTRIES];
  logic       flag     [MAX_ENTRIES];
  logic       valid    [MAX_ENTRIES];

  // same-start removal chain
  logic       rm_pre   [MAX_ENTRIES];
  logic             rm_any;
  logic [SIZE_W-1:0] rm_size;

  logic full;
  logic evict_go;
  logic accept;

  // newest-match select
  logic             sel_found;
  entry_t           sel_ent;

  logic [CW+3:0] count_wide;

  assign accept   = start && !busy;
  assign full     = (count == CW'(MAX_ENTRIES));
  assign evict_go = (count != '0) && (size_sum > {1'b0, byte_limit});

  assign lk.query  = req_query;
  assign lk.cue    = req_cue[START_W-1:0];
  assign lk.cue_hi = cue_hi;
  assign lk.tol    = cue_tol;
  assign lk.filter = !req_cue[END_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      assign valid[gi] = (CW'(gi) < count);
      if (gi == MAX_ENTRIES - 1) begin : g_last
        assign nbr[gi] = req;
      end else begin : g_mid
        assign nbr[gi] = ent[gi+1];
      end
      tfct_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[gi]),
        .nbr      (nbr[gi]),
        .fresh    (req),
        .lk       (lk),
        .ent      (ent[gi]),
        .start_eq (start_eq[gi]),
        .flag     (flag[gi])
      );
    end
  endgenerate

  // first valid cell with the new start; it and everything after it shift
  always_comb begin
    logic pre;
    pre     = 1'b0;
    rm_size = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!pre && start_eq[i] && valid[i]) begin
        rm_size = ent[i].size;
      end
      pre       = pre || (start_eq[i] && valid[i]);
      rm_pre[i] = pre;
    end
    rm_any = pre;
  end

  // newest flagged cell wins
  always_comb begin
    sel_found = 1'b0;
    sel_ent   = ent[0];
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!sel_found && flag[i] && valid[i]) begin
        sel_found = 1'b1;
        sel_ent   = ent[i];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode) begin
            state_next = ST_EVAL;
          end else if (frame_size == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_REMOVE;
          end
        end
      end
      ST_REMOVE: state_next = ST_APPEND;
      ST_APPEND: state_next = ST_EVICT;
      ST_EVICT:  state_next = evict_go ? ST_EVICT : ST_DONE;
      ST_EVAL:   state_next = ST_SELECT;
      ST_SELECT: state_next = ST_CLIP;
      ST_CLIP:   state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: cell control and table bookkeeping
  always_comb begin
    count_next    = count;
    size_sum_next = size_sum;
    ev_next       = ev;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctrl[i] = '0;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ev_next = '0;
        end
      end
      ST_REMOVE: begin
        if (rm_any) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].shift = rm_pre[i];
          end
          count_next    = count - CW'(1);
          size_sum_next = size_sum - {1'b0, rm_size};
          ev_next       = ev + EVC_W'(1);
        end
      end
      ST_APPEND: begin
        if (full) begin
          // oldest drops out as the new entry enters at the tail
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].shift = 1'b1;
          end
          size_sum_next = size_sum + {1'b0, req.size} - {1'b0, ent[0].size};
          ev_next       = ev + EVC_W'(1);
        end else begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].load = (count == CW'(i));
          end
          count_next    = count + CW'(1);
          size_sum_next = size_sum + {1'b0, req.size};
        end
      end
      ST_EVICT: begin
        if (evict_go) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].shift = 1'b1;
          end
          count_next    = count - CW'(1);
          size_sum_next = size_sum - {1'b0, ent[0].size};
          ev_next       = ev + EVC_W'(1);
        end
      end
      ST_EVAL: begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          ctrl[i].eval = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      size_sum   <= '0;
      byte_limit <= BYTE_LIMIT_RST;
      cue_tol    <= CUE_TOL_RST;
    end else begin
      state    <= state_next;
      count    <= count_next;
      size_sum <= size_sum_next;
      if (wr_en) begin
        case (wr_index)
          REG_BYTE_LIMIT: byte_limit <= wr_data;
          REG_CUE_TOL:    cue_tol    <= wr_data[TOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    ev <= ev_next;
    if (accept) begin
      req_mode     <= mode;
      req.begin_ms <= frame_start;
      req.end_ms   <= end_ms;
      req.size     <= frame_size;
      req_query    <= query_ms;
      req_cue      <= cue_start;
      cue_hi       <= {1'b0, cue_start[START_W-1:0]} +
                      {{(END_W-TOL_W){1'b0}}, cue_tol};
      hit_q        <= 1'b0;
      hs_q         <= '0;
      he_q         <= '0;
    end
    if (state == ST_SELECT) begin
      hit_q  <= sel_found;
      hs_q   <= sel_found ? sel_ent.begin_ms : '0;
      he_raw <= sel_ent.end_ms;
    end
    if (state == ST_CLIP && hit_q) begin
      // cue end clips only when it lies after the entry start
      if (req.end_ms > $signed({1'b0, hs_q}) && req.end_ms < he_raw) begin
        he_q <= req.end_ms[START_W-1:0];
      end else begin
        he_q <= he_raw[START_W-1:0];
      end
    end
  end

  assign count_wide = {4'b0, count};

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_DONE);
  assign hit          = hit_q;
  assign hit_start_ms = hs_q;
  assign hit_end_ms   = he_q;
  assign entry_count  = count_wide[3:0];
  assign total_size   = size_sum[SIZE_W-1:0];
  assign evicted      = ev;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_hit_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> req_mode)
    else $error("hit reported on insert");

  a_lookup_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && req_mode) |-> (evicted == '0))
    else $error("eviction reported on lookup");
`endif

endmodule
